### src/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by the parser, the result register and the top level.
package wsd_pkg;

    localparam int LEN_W = 63;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

    localparam logic KIND_UPGRADE = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    localparam logic WAIT_RESET = 1'b1;

    typedef struct packed {
        logic             hit;
        logic             event_kind;
        logic [3:0]       opcode;
        logic             fin;
        logic             masked;
        logic [LEN_W-1:0] frame_len;
    } t_result;

endpackage

### src/wsd_in_reg.sv
// Input register stage of the deframer: holds one received byte.
// Depends on nothing but the handshake from the result register.
module wsd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_advance,
    output logic       o_in_stall,
    output logic       o_held_valid,
    output logic [7:0] o_held_byte,
    output logic       o_step
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_load;

    // Refill when empty or when the held byte moves on this cycle
    assign w_load       = !r_valid || i_advance;
    assign o_in_stall   = !w_load;
    assign o_held_valid = r_valid;
    assign o_held_byte  = r_byte;
    assign o_step       = r_valid && i_advance;

    // Hold control under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx_byte;
        end
    end
endmodule

### src/wsd_parser.sv
// Header parser state machine of the deframer: one byte per step.
// Depends on wsd_pkg for constants and the result struct.
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wait,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_UPGRADE,
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASKKEY,
        PH_PAYLOAD
    } t_phase;

    t_phase           r_phase, n_phase;
    logic             r_wait;
    logic [1:0]       r_match, n_match;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_fin, n_fin;
    logic             r_masked, n_masked;
    logic [LEN_W-1:0] r_len, n_len;
    logic [3:0]       r_left, n_left;
    logic [LEN_W-1:0] r_rem, n_rem;

    logic             w_emit_up;
    logic             w_emit_frame;
    logic [7:0]       w_want;
    logic [LEN_W-1:0] w_len_shift;
    logic [LEN_W-1:0] w_len_start;
    logic             w_len_done;
    logic             w_start_payload;

    assign w_want      = r_match[0] ? CHAR_LF : CHAR_CR;
    assign w_len_shift = {r_len[LEN_W-9:0], i_byte};

    // Next state for one byte
    always_comb begin
        n_phase         = r_phase;
        n_match         = r_match;
        n_opcode        = r_opcode;
        n_fin           = r_fin;
        n_masked        = r_masked;
        n_len           = r_len;
        n_left          = r_left;
        n_rem           = r_rem;
        w_emit_up       = 1'b0;
        w_emit_frame    = 1'b0;
        w_len_done      = 1'b0;
        w_start_payload = 1'b0;
        w_len_start     = r_len;

        unique case (r_phase)
            PH_UPGRADE: begin
                if (i_byte == w_want) begin
                    if (r_match == 2'd3) begin
                        n_match   = 2'd0;
                        n_phase   = PH_HDR0;
                        w_emit_up = 1'b1;
                    end else begin
                        n_match = r_match + 2'd1;
                    end
                end else begin
                    n_match = (i_byte == CHAR_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_HDR0: begin
                n_opcode = i_byte[3:0];
                n_fin    = i_byte[7];
                n_masked = 1'b0;
                n_len    = '0;
                n_rem    = '0;
                n_left   = '0;
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_masked = i_byte[7];
                if (i_byte[6:0] == LEN7_EXT16 || i_byte[6:0] == LEN7_EXT64) begin
                    n_len   = '0;
                    n_left  = (i_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    n_phase = PH_EXTLEN;
                end else begin
                    n_len      = {{(LEN_W-7){1'b0}}, i_byte[6:0]};
                    w_len_done = 1'b1;
                end
            end
            PH_EXTLEN: begin
                n_len = w_len_shift;
                if (r_left != 4'd0) begin
                    n_left = r_left - 4'd1;
                end
                w_len_done = (r_left <= 4'd1);
            end
            PH_MASKKEY: begin
                if (r_left != 4'd0) begin
                    n_left = r_left - 4'd1;
                end
                w_start_payload = (r_left <= 4'd1);
            end
            PH_PAYLOAD: begin
                if (r_rem <= {{(LEN_W-1){1'b0}}, 1'b1}) begin
                    n_rem        = '0;
                    n_phase      = PH_HDR0;
                    w_emit_frame = 1'b1;
                end else begin
                    n_rem = r_rem - {{(LEN_W-1){1'b0}}, 1'b1};
                end
            end
            default: begin
                n_phase  = r_wait ? PH_UPGRADE : PH_HDR0;
                n_match  = '0;
                n_opcode = '0;
                n_fin    = 1'b0;
                n_masked = 1'b0;
                n_len    = '0;
                n_left   = '0;
                n_rem    = '0;
            end
        endcase

        // Length complete: read the masking key if masked, else go to the payload
        if (w_len_done) begin
            if (n_masked) begin
                n_left  = MASK_KEY_BYTES;
                n_phase = PH_MASKKEY;
            end else begin
                w_start_payload = 1'b1;
            end
        end

        // Start the payload, or finish at once on an empty one
        if (w_start_payload) begin
            w_len_start = n_len;
            if (w_len_start == '0) begin
                n_rem        = '0;
                n_phase      = PH_HDR0;
                w_emit_frame = 1'b1;
            end else begin
                n_rem   = w_len_start;
                n_phase = PH_PAYLOAD;
            end
        end
    end

    // Build the result; upgrade-end carries zero fields
    always_comb begin
        o_res                = '0;
        o_res.hit            = w_emit_up || w_emit_frame;
        o_res.event_kind     = w_emit_frame ? KIND_FRAME : KIND_UPGRADE;
        if (w_emit_frame) begin
            o_res.opcode    = n_opcode;
            o_res.fin       = n_fin;
            o_res.masked    = n_masked;
            o_res.frame_len = n_len;
        end
    end

    // Hold state; a register write restarts parsing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_wait   <= i_rst_n ? i_cfg_wait : WAIT_RESET;
            r_phase  <= (i_rst_n ? i_cfg_wait : WAIT_RESET) ? PH_UPGRADE : PH_HDR0;
            r_match  <= '0;
            r_opcode <= '0;
            r_fin    <= 1'b0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_left   <= '0;
            r_rem    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_left   <= n_left;
            r_rem    <= n_rem;
        end
    end
endmodule

### src/wsd_out_reg.sv
// Result register of the deframer: holds one event until transferred.
// Depends on wsd_pkg for the result struct.
module wsd_out_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  wsd_pkg::t_result          i_res,
    input  logic                      i_out_stall,
    output logic                      o_advance,
    output logic                      o_out_valid,
    output logic                      o_event_kind,
    output logic [3:0]                o_opcode,
    output logic                      o_fin,
    output logic                      o_masked,
    output logic [wsd_pkg::LEN_W-1:0] o_frame_len
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held event transfers now
    assign o_advance = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_step && i_res.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_event_kind = r_res.event_kind;
    assign o_opcode     = r_res.opcode;
    assign o_fin        = r_res.fin;
    assign o_masked     = r_res.masked;
    assign o_frame_len  = r_res.frame_len;
endmodule

### src/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_in_reg, wsd_parser and wsd_out_reg.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   rx in    | in        | i_in_valid / o_in_stall   | i_rx_byte
//   event    | out       | o_out_valid / i_out_stall | o_event_kind, o_opcode, o_fin,
//            |           |                           | o_masked, o_frame_len
//   config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (wait_for_upgrade)
//
// One byte per cycle while the event channel does not stall. A byte is held in the input
// register after transfer; its event, if any, enters the result register as it moves on.
// Synchronous active-low reset clears control; wait_for_upgrade resets to 1.
// A stall on the event channel while an event is held holds the result register and the
// input register, which backs up the rx channel once it holds a byte. A config write restarts parsing.
module websocket_frame_deframer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_rx_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_event_kind,
    output logic [3:0]                o_opcode,
    output logic                      o_fin,
    output logic                      o_masked,
    output logic [wsd_pkg::LEN_W-1:0] o_frame_len,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_data
);
    import wsd_pkg::*;

    logic       w_advance;
    logic       w_held_valid;
    logic [7:0] w_held_byte;
    logic       w_step;
    t_result    w_res;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    wsd_in_reg u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_rx_byte    (i_rx_byte),
        .i_advance    (w_advance),
        .o_in_stall   (o_in_stall),
        .o_held_valid (w_held_valid),
        .o_held_byte  (w_held_byte),
        .o_step       (w_step)
    );

    wsd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (w_held_byte),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_wait (i_cfg_data),
        .o_res      (w_res)
    );

    wsd_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_res        (w_res),
        .i_out_stall  (i_out_stall),
        .o_advance    (w_advance),
        .o_out_valid  (o_out_valid),
        .o_event_kind (o_event_kind),
        .o_opcode     (o_opcode),
        .o_fin        (o_fin),
        .o_masked     (o_masked),
        .o_frame_len  (o_frame_len)
    );

    // Upgrade-end events carry zero header fields
    a_upgrade_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == KIND_UPGRADE) |->
        (o_opcode == 4'd0 && !o_fin && !o_masked && o_frame_len == '0))
        else $error("upgrade event with nonzero fields");

    // Input stalls only when a byte is already held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_held_valid)
        else $error("input stalled with empty input register");

    // A transferred event with no byte behind it leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !w_held_valid) |=> !o_out_valid)
        else $error("event invented without input");
endmodule
